// ===== rtl/core/uilu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes of the unimodular integer LU solver.
package uilu_pkg;

    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = IDX_W + 1;
    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    // Cycles left for the last token of a step to cross the chain and retire.
    localparam int DRAIN_LEN = MAX_DIM + 4;
    localparam int DRAIN_W   = $clog2(DRAIN_LEN + 1);

    localparam logic [DATA_W-1:0] NEG_ONE = '1;
    localparam logic [DATA_W-1:0] POS_ONE = DATA_W'(1);

    localparam logic [1:0] KIND_MATRIX = 2'd0;
    localparam logic [1:0] KIND_VECTOR = 2'd1;
    localparam logic [1:0] KIND_SOLVE  = 2'd2;

    typedef enum logic [1:0] {
        CTL_LATCH,
        CTL_ELIM,
        CTL_BACK
    } ctl_op_t;

    typedef enum logic [1:0] {
        TK_ELIM,
        TK_BACK,
        TK_SCALE
    } tok_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LATCH,
        S_CHECK,
        S_ELIM,
        S_DRAIN,
        S_BACK,
        S_BDRAIN,
        S_COPY,
        S_EMIT,
        S_ERR
    } state_t;

    typedef struct packed {
        logic              valid;
        tok_op_t           op;
        logic [IDX_W-1:0]  row;
        logic [DATA_W-1:0] value;
    } tok_t;

    typedef struct packed {
        logic              issue;
        ctl_op_t           op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  step;
        logic [DIM_W-1:0]  dim;
        logic              ld_mat;
        logic              ld_vec;
        logic [IDX_W-1:0]  ld_row;
        logic [IDX_W-1:0]  ld_col;
        logic [DATA_W-1:0] ld_value;
        logic              copy_in;
        logic              copy_out;
        logic [IDX_W-1:0]  rd_idx;
    } ctl_t;

endpackage

// ===== rtl/core/uilu_mac.sv =====
`timescale 1ns / 1ps
// Registered wrapping multiply-subtract: old minus the low 64 bits of a times b.
module uilu_mac
    import uilu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [IDX_W-1:0]  in_row,
    input  logic [DATA_W-1:0] old_value,
    input  logic [DATA_W-1:0] mul_a,
    input  logic [DATA_W-1:0] mul_b,
    output logic              res_valid,
    output logic [IDX_W-1:0]  res_row,
    output logic [DATA_W-1:0] res_value
);

    logic              vld_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [DATA_W-1:0] old_reg;
    logic [DATA_W-1:0] p0_reg;
    logic [HALF_W-1:0] p1_reg;
    logic [HALF_W-1:0] p2_reg;
    logic [DATA_W-1:0] p0_next;
    logic [HALF_W-1:0] p1_next;
    logic [HALF_W-1:0] p2_next;
    logic [HALF_W-1:0] cross_sum;

    // Only the low halves of the cross products reach the low 64 bits.
    assign p0_next = mul_a[HALF_W-1:0] * mul_b[HALF_W-1:0];
    assign p1_next = mul_a[HALF_W-1:0] * mul_b[DATA_W-1:HALF_W];
    assign p2_next = mul_a[DATA_W-1:HALF_W] * mul_b[HALF_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= in_row;
        old_reg <= old_value;
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
    end

    assign cross_sum = p1_reg + p2_reg;
    assign res_valid = vld_reg;
    assign res_row   = row_reg;
    assign res_value = old_reg - (p0_reg + {cross_sum, {HALF_W{1'b0}}});

endmodule

// ===== rtl/core/uilu_cell.sv =====
`timescale 1ns / 1ps
// One matrix column cell of the chain: column storage, pivot row latch and update.
module uilu_cell
    import uilu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  idx,
    input  ctl_t              ctl,
    input  tok_t              tok_in,
    output tok_t              tok_out,
    output logic [DATA_W-1:0] pivot
);

    logic [DATA_W-1:0] col_reg [MAX_DIM];
    logic [DATA_W-1:0] pk_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic              latch;
    logic              origin;
    logic              update;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] mult;
    logic              mac_valid;
    logic [IDX_W-1:0]  mac_row;
    logic [DATA_W-1:0] mac_value;

    always_comb
    begin
        latch  = ctl.issue && (ctl.op == CTL_LATCH);
        origin = ctl.issue && (ctl.op != CTL_LATCH) && (ctl.step == idx);
        update = tok_in.valid && (tok_in.op == TK_ELIM) && (idx > ctl.step)
                 && ({1'b0, idx} < ctl.dim);
        rd_addr = tok_in.row;
        if (latch)
        begin
            rd_addr = ctl.step;
        end
        else if (origin)
        begin
            rd_addr = ctl.row;
        end
        rd_data = col_reg[rd_addr];
        // The pivot is plus or minus one, so the multiplier is a conditional negation.
        mult = (pk_reg == NEG_ONE) ? (DATA_W'(0) - rd_data) : rd_data;
        tok_next = tok_in;
        if (origin)
        begin
            tok_next.valid = 1'b1;
            tok_next.row   = ctl.row;
            if (ctl.op == CTL_ELIM)
            begin
                tok_next.op    = TK_ELIM;
                tok_next.value = mult;
            end
            else
            begin
                tok_next.op    = (ctl.row == idx) ? TK_SCALE : TK_BACK;
                tok_next.value = rd_data;
            end
        end
    end

    uilu_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (update),
        .in_row    (tok_in.row),
        .old_value (rd_data),
        .mul_a     (tok_in.value),
        .mul_b     (pk_reg),
        .res_valid (mac_valid),
        .res_row   (mac_row),
        .res_value (mac_value)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.ld_mat && (ctl.ld_col == idx))
        begin
            col_reg[ctl.ld_row] <= ctl.ld_value;
        end
        else if (origin && (ctl.op == CTL_ELIM))
        begin
            col_reg[ctl.row] <= mult;
        end
        else if (mac_valid)
        begin
            col_reg[mac_row] <= mac_value;
        end
        if (latch)
        begin
            pk_reg <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign pivot   = pk_reg;

endmodule

// ===== rtl/core/uilu_vcell.sv =====
`timescale 1ns / 1ps
// End cell of the chain: right-hand side, working vector and substitution updates.
module uilu_vcell
    import uilu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    input  tok_t              tok_in,
    output logic [DATA_W-1:0] rd_value
);

    logic [DATA_W-1:0] w_reg [MAX_DIM];
    logic [DATA_W-1:0] v_reg [MAX_DIM];
    logic [DATA_W-1:0] wk_reg;
    logic [DATA_W-1:0] xj_reg;
    logic              latch;
    logic              scale;
    logic              mac_in;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] scaled;
    logic [DATA_W-1:0] mul_b;
    logic              mac_valid;
    logic [IDX_W-1:0]  mac_row;
    logic [DATA_W-1:0] mac_value;

    always_comb
    begin
        latch   = ctl.issue && (ctl.op == CTL_LATCH);
        scale   = tok_in.valid && (tok_in.op == TK_SCALE);
        mac_in  = tok_in.valid && (tok_in.op != TK_SCALE);
        rd_addr = latch ? ctl.step : tok_in.row;
        rd_data = w_reg[rd_addr];
        scaled  = (tok_in.value == NEG_ONE) ? (DATA_W'(0) - rd_data) : rd_data;
        mul_b   = (tok_in.op == TK_ELIM) ? wk_reg : xj_reg;
    end

    uilu_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mac_in),
        .in_row    (tok_in.row),
        .old_value (rd_data),
        .mul_a     (tok_in.value),
        .mul_b     (mul_b),
        .res_valid (mac_valid),
        .res_row   (mac_row),
        .res_value (mac_value)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.copy_in)
        begin
            for (int e = 0; e < MAX_DIM; e++)
            begin
                w_reg[e] <= v_reg[e];
            end
        end
        else if (scale)
        begin
            w_reg[tok_in.row] <= scaled;
        end
        else if (mac_valid)
        begin
            w_reg[mac_row] <= mac_value;
        end
        if (ctl.copy_out)
        begin
            for (int e = 0; e < MAX_DIM; e++)
            begin
                v_reg[e] <= w_reg[e];
            end
        end
        else if (ctl.ld_vec)
        begin
            v_reg[ctl.ld_row] <= ctl.ld_value;
        end
        if (latch)
        begin
            wk_reg <= rd_data;
        end
        if (scale)
        begin
            xj_reg <= scaled;
        end
    end

    assign rd_value = v_reg[ctl.rd_idx];

endmodule

// ===== rtl/core/unimodular_integer_lu_solver.sv =====
`timescale 1ns / 1ps
// Top level of the unimodular integer LU solver: sequencer, cell chain and result register.
//
// Items enter on the input channel (in_valid / in_stall). Matrix loads and
// right-hand-side loads are taken while the block is idle, one per cycle.
// A solve item with a non-zero dimension n (saturated to 16) makes the block
// stall its input until the whole run has been handed to the result register.
// The matrix is held by a chain of sixteen column cells, followed by a cell
// that holds the right-hand side. Each elimination step latches the pivot
// row, checks the pivot, then issues one token per row below the pivot; the
// token travels one cell per cycle along the chain and every later column
// updates its entry. The right-hand side is reduced by the same tokens.
// Back substitution sends tokens from each column to the vector cell.
// Each elimination step but the last, and each back-substitution column,
// ends with a drain for the chain and multiplier. A bad pivot ends the run
// early with a single error item. Results leave through a registered output
// (out_valid / out_stall); while the receiver stalls, the item is held and the
// sequencer waits. Reset clears the control state; the stored matrix and
// vector are undefined until loaded.
module unimodular_integer_lu_solver
    import uilu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [IDX_W-1:0]  row,
    input  logic [IDX_W-1:0]  column,
    input  logic [DATA_W-1:0] element_value,
    input  logic [DIM_W-1:0]  dimension,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] solution_value,
    output logic [IDX_W-1:0]  solution_index,
    output logic              last,
    output logic              pivot_error
);

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  e_reg;
    logic [DIM_W-1:0]  n_reg;
    logic [DRAIN_W-1:0] dcnt_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              last_reg;
    logic              err_reg;

    logic              in_acc;
    logic              solve_go;
    logic              out_free;
    logic              load_emit;
    logic              load_err;
    logic [DIM_W-1:0]  n_sat;
    logic [DIM_W-1:0]  n_last;
    logic [DATA_W-1:0] piv;
    logic              bad_pivot;
    logic              drain_end;
    logic [DATA_W-1:0] vec_value;
    ctl_t              ctl;
    tok_t              chain [MAX_DIM+1];
    logic [DATA_W-1:0] pivots [MAX_DIM];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign n_sat     = (dimension > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dimension;
    assign solve_go  = in_acc && (kind == KIND_SOLVE) && (n_sat != '0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign n_last    = n_reg - DIM_W'(1);
    assign piv       = pivots[k_reg];
    assign bad_pivot = (piv != POS_ONE) && (piv != NEG_ONE);
    assign drain_end = (dcnt_reg == DRAIN_W'(DRAIN_LEN - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (solve_go)
                begin
                    state_next = S_LATCH;
                end
            end
            S_LATCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (bad_pivot)
                begin
                    state_next = S_ERR;
                end
                else if ({1'b0, k_reg} == n_last)
                begin
                    state_next = S_BACK;
                end
                else
                begin
                    state_next = S_ELIM;
                end
            end
            S_ELIM:
            begin
                if ({1'b0, i_reg} == n_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_end)
                begin
                    state_next = S_LATCH;
                end
            end
            S_BACK:
            begin
                if (i_reg == '0)
                begin
                    state_next = S_BDRAIN;
                end
            end
            S_BDRAIN:
            begin
                if (drain_end)
                begin
                    state_next = (k_reg == '0) ? S_COPY : S_BACK;
                end
            end
            S_COPY:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free && ({1'b0, e_reg} == n_last))
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controls to the chain and the result register.
    always_comb
    begin
        ctl          = '0;
        ctl.op       = CTL_LATCH;
        ctl.row      = i_reg;
        ctl.step     = k_reg;
        ctl.dim      = n_reg;
        ctl.ld_row   = row;
        ctl.ld_col   = column;
        ctl.ld_value = element_value;
        ctl.rd_idx   = e_reg;
        load_emit    = 1'b0;
        load_err     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.ld_mat  = in_acc && (kind == KIND_MATRIX);
                ctl.ld_vec  = in_acc && (kind == KIND_VECTOR);
                ctl.copy_in = solve_go;
            end
            S_LATCH:
            begin
                ctl.issue = 1'b1;
                ctl.op    = CTL_LATCH;
            end
            S_ELIM:
            begin
                ctl.issue = 1'b1;
                ctl.op    = CTL_ELIM;
            end
            S_DRAIN:
            begin
                ctl.op = CTL_ELIM;
            end
            S_BACK:
            begin
                ctl.issue = 1'b1;
                ctl.op    = CTL_BACK;
            end
            S_BDRAIN:
            begin
                ctl.op = CTL_BACK;
            end
            S_COPY:
            begin
                ctl.copy_out = 1'b1;
            end
            S_EMIT:
            begin
                load_emit = out_free;
            end
            S_ERR:
            begin
                load_err = out_free;
            end
            default:
            begin
                ctl.op = CTL_LATCH;
            end
        endcase
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < MAX_DIM; g++)
    begin : g_cell
        uilu_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (IDX_W'(g)),
            .ctl     (ctl),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1]),
            .pivot   (pivots[g])
        );
    end

    uilu_vcell u_vcell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .tok_in   (chain[MAX_DIM]),
        .rd_value (vec_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            i_reg         <= '0;
            e_reg         <= '0;
            n_reg         <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (solve_go)
            begin
                n_reg <= n_sat;
                k_reg <= '0;
                e_reg <= '0;
            end
            if ((state_reg == S_CHECK) && !bad_pivot)
            begin
                i_reg <= ({1'b0, k_reg} == n_last) ? k_reg : k_reg + IDX_W'(1);
            end
            if (state_reg == S_ELIM)
            begin
                i_reg <= i_reg + IDX_W'(1);
            end
            if (state_reg == S_BACK)
            begin
                i_reg <= i_reg - IDX_W'(1);
            end
            if ((state_reg == S_DRAIN) || (state_reg == S_BDRAIN))
            begin
                dcnt_reg <= drain_end ? '0 : dcnt_reg + DRAIN_W'(1);
            end
            if ((state_reg == S_DRAIN) && drain_end)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
            if ((state_reg == S_BDRAIN) && drain_end && (k_reg != '0))
            begin
                k_reg <= k_reg - IDX_W'(1);
                i_reg <= k_reg - IDX_W'(1);
            end
            if (load_emit)
            begin
                e_reg <= e_reg + IDX_W'(1);
            end
            if (load_emit || load_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_emit)
        begin
            value_reg <= vec_value;
            index_reg <= e_reg;
            last_reg  <= ({1'b0, e_reg} == n_last);
            err_reg   <= 1'b0;
        end
        else if (load_err)
        begin
            value_reg <= '0;
            index_reg <= k_reg;
            last_reg  <= 1'b1;
            err_reg   <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign solution_value = value_reg;
    assign solution_index = index_reg;
    assign last           = last_reg;
    assign pivot_error    = err_reg;

endmodule

// ===== rtl/core/uilu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the unimodular integer LU solver and its bind.
module uilu_checker
    import uilu_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [1:0]        kind,
    input logic [DIM_W-1:0]  dimension,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DATA_W-1:0] solution_value,
    input logic [IDX_W-1:0]  solution_index,
    input logic              last,
    input logic              pivot_error
);

    // A result held under stall keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(solution_value)
            && $stable(solution_index) && $stable(last) && $stable(pivot_error))
        else $error("stalled result changed");

    // An error item is the only and final item of its run, with a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pivot_error |-> last && (solution_value == '0))
        else $error("malformed pivot error item");

    // A solve with work to do holds off the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_SOLVE) && (dimension != '0) |=> in_stall)
        else $error("input taken during a solve");

    // While a result other than the last is on offer, the run is still going.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("run ended before its last item");

endmodule

bind unimodular_integer_lu_solver uilu_checker u_uilu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .dimension      (dimension),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .solution_value (solution_value),
    .solution_index (solution_index),
    .last           (last),
    .pivot_error    (pivot_error)
);

// ===== verif/tb_unimodular_integer_lu_solver.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the unimodular integer LU solver.
module tb_unimodular_integer_lu_solver;
    import uilu_pkg::*;

    // Kind code that the block must ignore.
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 420;
    // Bound on the total simulated cycles, well above what a correct simulation needs.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 200;
    localparam int N_DIR        = 22;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  column;
        logic [DATA_W-1:0] value;
        logic [DIM_W-1:0]  dim;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic              last;
        logic              error;
    } sol_t;

    typedef struct packed {
        item_t it;
        logic  typed;
        sol_t  res;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        kind;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  column;
    logic [DATA_W-1:0] element_value;
    logic [DIM_W-1:0]  dimension;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] solution_value;
    logic [IDX_W-1:0]  solution_index;
    logic              last;
    logic              pivot_error;

    // Shadow copy of the block's matrix and right-hand side, with flags that
    // record which entries have been written so that a solve never reads an
    // entry whose content is undefined.
    logic [DATA_W-1:0] shadow_mat [MAX_DIM][MAX_DIM];
    logic [DATA_W-1:0] shadow_vec [MAX_DIM];
    bit                mat_written [MAX_DIM][MAX_DIM];
    bit                vec_written [MAX_DIM];

    sol_t     solution_q[$];
    int       mismatches;
    int       cycles;
    int       live_items;
    bit       quiet;
    dir_row_t directed [N_DIR];

    unimodular_integer_lu_solver i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .row            (row),
        .column         (column),
        .element_value  (element_value),
        .dimension      (dimension),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .solution_value (solution_value),
        .solution_index (solution_index),
        .last           (last),
        .pivot_error    (pivot_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A run that hangs is ended here rather than left to run for ever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Small signed value in the range -3..3, sign extended to the data width.
    function automatic logic [DATA_W-1:0] rand_small();
        return DATA_W'(signed'(32'($urandom_range(0, 6)) - 32'sd3));
    endfunction

    // True when every entry that a solve of size n reads has been written.
    function automatic bit leading_written(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (!vec_written[i])
                return 1'b0;
            for (int j = 0; j < n; j++)
                if (!mat_written[i][j])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Factors the leading n-by-n part in place, with multipliers scaled by the
    // pivot, then runs the forward and back passes on the shadow vector. The
    // solution, or a single error item, is appended to the given queue.
    task automatic lu_solve(input int n, ref sol_t sol_q[$]);
        logic [DATA_W-1:0] pivot;
        logic [DATA_W-1:0] mult;
        logic [DATA_W-1:0] acc;
        int                bad;
        sol_t              s;
        bad = n;
        for (int k = 0; k < n; k++)
        begin
            pivot = shadow_mat[k][k];
            if (pivot != POS_ONE && pivot != NEG_ONE)
            begin
                bad = k;
                break;
            end
            for (int i = k + 1; i < n; i++)
            begin
                mult = shadow_mat[i][k];
                if (mult != '0)
                begin
                    mult = mult * pivot;
                    shadow_mat[i][k] = mult;
                    for (int j = k + 1; j < n; j++)
                        shadow_mat[i][j] = shadow_mat[i][j] - mult * shadow_mat[k][j];
                end
            end
        end
        if (bad < n)
        begin
            s = '{value: '0, index: IDX_W'(bad), last: 1'b1, error: 1'b1};
            sol_q.push_back(s);
            return;
        end
        for (int i = 1; i < n; i++)
        begin
            acc = '0;
            for (int j = 0; j < i; j++)
                acc += shadow_mat[i][j] * shadow_vec[j];
            shadow_vec[i] -= acc;
        end
        shadow_vec[n-1] *= shadow_mat[n-1][n-1];
        for (int i = n - 2; i >= 0; i--)
        begin
            acc = '0;
            for (int j = i + 1; j < n; j++)
                acc += shadow_mat[i][j] * shadow_vec[j];
            shadow_vec[i] = (shadow_vec[i] - acc) * shadow_mat[i][i];
        end
        for (int i = 0; i < n; i++)
        begin
            s = '{value: shadow_vec[i], index: IDX_W'(i), last: (i == n - 1), error: 1'b0};
            sol_q.push_back(s);
        end
    endtask

    // Offers one item after a random gap and waits for it to be taken. On
    // acceptance the shadow state is updated and the expected solution is
    // queued; a typed expectation replaces the predicted one where given.
    task automatic send_item(input item_t it, input bit typed, input sol_t typed_res);
        int   gap;
        int   n;
        sol_t scratch[$];
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= it.kind;
        row           <= it.row;
        column        <= it.column;
        element_value <= it.value;
        dimension     <= it.dim;
        do
            @(posedge clk);
        while (in_stall);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        n = (it.dim > MAX_DIM) ? MAX_DIM : int'(it.dim);
        case (it.kind)
            KIND_MATRIX:
            begin
                shadow_mat[it.row][it.column]  = it.value;
                mat_written[it.row][it.column] = 1'b1;
                live_items++;
            end
            KIND_VECTOR:
            begin
                shadow_vec[it.row]  = it.value;
                vec_written[it.row] = 1'b1;
                live_items++;
            end
            KIND_SOLVE:
            begin
                if (n > 0)
                begin
                    live_items++;
                    if (typed)
                    begin
                        lu_solve(n, scratch);
                        solution_q.push_back(typed_res);
                    end
                    else
                        lu_solve(n, solution_q);
                end
            end
            default: ;
        endcase
    endtask

    // Loads a random unimodular system of size n, built as L*U with a unit
    // lower factor and an upper factor whose diagonal is +1 or -1, so that the
    // elimination succeeds. A perturbed entry, added now and then, may spoil a pivot.
    task automatic load_system(input int n);
        logic [DATA_W-1:0] lo [MAX_DIM][MAX_DIM];
        logic [DATA_W-1:0] up [MAX_DIM][MAX_DIM];
        logic [DATA_W-1:0] a;
        bit                wide;
        item_t             it;
        wide = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                lo[i][j] = (i == j) ? POS_ONE : (j < i ? rand_small() : '0);
                if (i == j)
                    up[i][j] = $urandom_range(0, 1) ? POS_ONE : NEG_ONE;
                else if (j > i)
                    up[i][j] = wide ? rand64() : rand_small();
                else
                    up[i][j] = '0;
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                a = '0;
                for (int k = 0; k <= i && k <= j; k++)
                    a += lo[i][k] * up[k][j];
                it = '{kind: KIND_MATRIX, row: IDX_W'(i), column: IDX_W'(j), value: a, dim: '0};
                send_item(it, 1'b0, '0);
            end
        for (int i = 0; i < n; i++)
        begin
            it = '{kind: KIND_VECTOR, row: IDX_W'(i), column: IDX_W'($urandom),
                   value: wide ? rand64() : rand_small(), dim: DIM_W'($urandom)};
            send_item(it, 1'b0, '0);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            it = '{kind: KIND_MATRIX, row: IDX_W'($urandom_range(0, n - 1)),
                   column: IDX_W'($urandom_range(0, n - 1)), value: rand64(), dim: '0};
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result side: stalls for a random number of cycles before each item,
    // except during quiet stretches.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Every result taken is compared with the oldest expectation.
    always @(posedge clk)
    begin
        sol_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (solution_q.size() == 0)
                report_mismatch("result with none expected", solution_value, '0);
            else
            begin
                want = solution_q.pop_front();
                if (solution_value !== want.value)
                    report_mismatch("solution_value", solution_value, want.value);
                if (solution_index !== want.index)
                    report_mismatch("solution_index", DATA_W'(solution_index),
                                    DATA_W'(want.index));
                if (last !== want.last)
                    report_mismatch("last", DATA_W'(last), DATA_W'(want.last));
                if (pivot_error !== want.error)
                    report_mismatch("pivot_error", DATA_W'(pivot_error), DATA_W'(want.error));
            end
        end
    end

    initial
    begin
        item_t it;
        int    n;
        int    pick;
        int    wait_cycles;
        bit    first_job;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_MATRIX;
        row           = '0;
        column        = '0;
        element_value = '0;
        dimension     = '0;
        mismatches    = 0;
        cycles        = 0;
        live_items    = 0;
        quiet         = 1'b0;
        first_job     = 1'b1;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            shadow_vec[i]  = '0;
            vec_written[i] = 1'b0;
            for (int j = 0; j < MAX_DIM; j++)
            begin
                shadow_mat[i][j]  = '0;
                mat_written[i][j] = 1'b0;
            end
        end

        // Directed rows: 1x1 systems with extreme values and pivots of both
        // signs, a bad pivot at the first and at a later step, an ignored kind,
        // a zero dimension, a 2x2 system solved twice in place, corner indices.
        directed = '{
            '{'{KIND_MATRIX, 4'd0, 4'd0, POS_ONE, 5'd0}, 1'b0, '0},
            '{'{KIND_VECTOR, 4'd0, 4'd15, 64'h8000_0000_0000_0000, 5'd31}, 1'b0, '0},
            '{'{KIND_SOLVE, 4'd0, 4'd0, 64'd0, 5'd1}, 1'b1,
              '{64'h8000_0000_0000_0000, 4'd0, 1'b1, 1'b0}},
            '{'{KIND_MATRIX, 4'd0, 4'd0, NEG_ONE, 5'd0}, 1'b0, '0},
            '{'{KIND_VECTOR, 4'd0, 4'd0, 64'h7FFF_FFFF_FFFF_FFFF, 5'd0}, 1'b0, '0},
            '{'{KIND_SOLVE, 4'd15, 4'd15, NEG_ONE, 5'd1}, 1'b1,
              '{64'h8000_0000_0000_0001, 4'd0, 1'b1, 1'b0}},
            '{'{KIND_MATRIX, 4'd0, 4'd0, 64'd2, 5'd0}, 1'b0, '0},
            '{'{KIND_SOLVE, 4'd0, 4'd0, 64'd0, 5'd1}, 1'b1, '{64'd0, 4'd0, 1'b1, 1'b1}},
            '{'{KIND_NONE, 4'd15, 4'd15, NEG_ONE, 5'd31}, 1'b0, '0},
            '{'{KIND_SOLVE, 4'd0, 4'd0, 64'd0, 5'd0}, 1'b0, '0},
            '{'{KIND_MATRIX, 4'd0, 4'd0, POS_ONE, 5'd0}, 1'b0, '0},
            '{'{KIND_MATRIX, 4'd0, 4'd1, 64'd3, 5'd0}, 1'b0, '0},
            '{'{KIND_MATRIX, 4'd1, 4'd0, 64'd2, 5'd0}, 1'b0, '0},
            '{'{KIND_MATRIX, 4'd1, 4'd1, 64'd7, 5'd0}, 1'b0, '0},
            '{'{KIND_VECTOR, 4'd0, 4'd0, 64'd5, 5'd0}, 1'b0, '0},
            '{'{KIND_VECTOR, 4'd1, 4'd0, -64'sd4, 5'd0}, 1'b0, '0},
            '{'{KIND_SOLVE, 4'd0, 4'd0, 64'd0, 5'd2}, 1'b0, '0},
            '{'{KIND_SOLVE, 4'd0, 4'd0, 64'd0, 5'd2}, 1'b0, '0},
            // Row one then reduces to -6 at the second step.
            '{'{KIND_MATRIX, 4'd1, 4'd1, 64'd0, 5'd0}, 1'b0, '0},
            '{'{KIND_SOLVE, 4'd0, 4'd0, 64'd0, 5'd2}, 1'b1, '{64'd0, 4'd1, 1'b1, 1'b1}},
            '{'{KIND_MATRIX, 4'd15, 4'd15, 64'h5555_5555_5555_5555, 5'd0}, 1'b0, '0},
            '{'{KIND_VECTOR, 4'd15, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA, 5'd0}, 1'b0, '0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int d = 0; d < N_DIR; d++)
            send_item(directed[d].it, directed[d].typed, directed[d].res);

        // Random part: mostly well-formed systems, sometimes solved again in
        // place, mixed with stray loads, ignored kinds and oversize dimensions.
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (first_job || pick < 65)
            begin
                n = first_job ? MAX_DIM
                    : ($urandom_range(0, 19) == 0 ? $urandom_range(6, 10)
                                                  : $urandom_range(1, 5));
                first_job = 1'b0;
                load_system(n);
                it = '{kind: KIND_SOLVE, row: IDX_W'($urandom), column: IDX_W'($urandom),
                       value: rand64(), dim: DIM_W'(n)};
                if (n == MAX_DIM)
                    it.dim = DIM_W'($urandom_range(MAX_DIM, 31));
                send_item(it, 1'b0, '0);
                if ($urandom_range(0, 4) == 0)
                    send_item(it, 1'b0, '0);
            end
            else
            begin
                it = '{kind: 2'($urandom), row: IDX_W'($urandom), column: IDX_W'($urandom),
                       value: rand64(), dim: DIM_W'($urandom)};
                n = (it.dim > MAX_DIM) ? MAX_DIM : int'(it.dim);
                if (it.kind == KIND_SOLVE && !leading_written(n))
                    it.dim = '0;
                send_item(it, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (solution_q.size() != 0 && wait_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE) @(posedge clk);
        if (solution_q.size() != 0)
        begin
            $display("%0d expected results never arrived", solution_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
